[hw/rtl/u2g_pkg.sv]
`timescale 1ns / 1ps

package u2g_pkg;

  localparam logic [1:0] CMD_DECODE = 2'd0;
  localparam logic [1:0] CMD_LOAD   = 2'd1;
  localparam logic [1:0] CMD_FLUSH  = 2'd2;

  localparam logic CFG_REPLACEMENT = 1'b0;
  localparam logic CFG_ENTRIES_USED = 1'b1;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;

  localparam logic [7:0] REPLACEMENT_RESET = 8'd63;

  typedef enum logic [1:0] {
    TAIL_NONE,
    TAIL_BAD,
    TAIL_CP
  } tail_t;

  // One unit of work for the back end: either a table load, or a run of
  // replacement results followed by an optional final result.
  typedef struct packed {
    logic        is_load;
    logic [1:0]  flush_count;
    tail_t       tail;
    logic [20:0] cp;
    logic [5:0]  idx;
    logic [7:0]  glyph;
  } job_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_FLUSH,
    BK_TAIL,
    BK_CMP,
    BK_EMIT
  } bk_state_t;

endpackage

[hw/rtl/u2g_ram.sv]
`timescale 1ns / 1ps

module u2g_ram #(
  parameter int WIDTH = 29,
  parameter int DEPTH = 64,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[hw/rtl/u2g_front.sv]
`timescale 1ns / 1ps

module u2g_front #(
  parameter int MAP_ENTRIES = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        command,
  input  logic [7:0]        data_byte,
  input  logic [5:0]        entry_index,
  input  logic [20:0]       entry_codepoint,
  input  logic [7:0]        entry_glyph,
  input  logic              q_full,
  output logic              q_push,
  output u2g_pkg::job_t     q_job
);

  logic [7:0] pend [3];
  logic [7:0] pend_next [3];
  logic [1:0] pc;
  logic [1:0] pc_next;
  logic [2:0] el;
  logic [2:0] el_next;
  logic       accept;
  logic       is_flush;
  logic       in_range;
  logic [2:0] lead_len;
  logic [20:0] cp_done;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign is_flush = (command == u2g_pkg::CMD_FLUSH) ||
                    ((command == u2g_pkg::CMD_DECODE) && (data_byte == 8'h00));
  assign in_range = ({5'b0, entry_index} < 11'(MAP_ENTRIES));

  always_comb begin
    if ((data_byte & 8'he0) == 8'hc0) begin
      lead_len = 3'd2;
    end else if ((data_byte & 8'hf0) == 8'he0) begin
      lead_len = 3'd3;
    end else if ((data_byte & 8'hf8) == 8'hf0) begin
      lead_len = 3'd4;
    end else begin
      lead_len = 3'd0;
    end
  end

  // Length and count advance together, so the count alone picks the lead mask.
  always_comb begin
    case (pc)
      2'd1: cp_done = {10'b0, pend[0][4:0], data_byte[5:0]};
      2'd2: cp_done = {5'b0, pend[0][3:0], pend[1][5:0], data_byte[5:0]};
      default: cp_done = {pend[0][2:0], pend[1][5:0], pend[2][5:0], data_byte[5:0]};
    endcase
  end

  always_comb begin
    q_job       = '0;
    q_job.tail  = u2g_pkg::TAIL_NONE;
    q_push      = 1'b0;
    pc_next     = pc;
    el_next     = el;
    pend_next   = pend;
    if (command == u2g_pkg::CMD_LOAD) begin
      q_job.is_load = 1'b1;
      q_job.idx     = entry_index;
      q_job.cp      = entry_codepoint;
      q_job.glyph   = entry_glyph;
      q_push        = in_range;
    end else if (is_flush) begin
      q_job.flush_count = pc;
      q_push            = (pc != 2'd0);
      pc_next           = 2'd0;
      el_next           = 3'd0;
    end else if (command == u2g_pkg::CMD_DECODE) begin
      if ((pc != 2'd0) && (data_byte[7:6] == 2'b10)) begin
        if (({1'b0, pc} + 3'd1) < el) begin
          pend_next[pc] = data_byte;
          pc_next       = pc + 2'd1;
        end else begin
          q_job.tail = u2g_pkg::TAIL_CP;
          q_job.cp   = cp_done;
          q_push     = 1'b1;
          pc_next    = 2'd0;
          el_next    = 3'd0;
        end
      end else begin
        // Flush whatever is open, then decode the byte as a fresh start.
        q_job.flush_count = pc;
        pc_next           = 2'd0;
        el_next           = 3'd0;
        if (data_byte[7] == 1'b0) begin
          q_job.tail = u2g_pkg::TAIL_CP;
          q_job.cp   = {13'b0, data_byte};
          q_push     = 1'b1;
        end else if (lead_len != 3'd0) begin
          pend_next[0] = data_byte;
          pc_next      = 2'd1;
          el_next      = lead_len;
          q_push       = (pc != 2'd0);
        end else begin
          q_job.tail = u2g_pkg::TAIL_BAD;
          q_push     = 1'b1;
        end
      end
    end
    q_push = q_push && accept;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= 2'd0;
      el <= 3'd0;
      pend[0] <= 8'h00;
      pend[1] <= 8'h00;
      pend[2] <= 8'h00;
    end else if (accept) begin
      pc   <= pc_next;
      el   <= el_next;
      pend <= pend_next;
    end
  end

`ifndef SYNTHESIS
  a_idle_len: assert property (@(posedge clk) disable iff (rst)
    (pc == 2'd0) |-> (el == 3'd0))
    else $error("front: length set with no open sequence");
  a_open_len: assert property (@(posedge clk) disable iff (rst)
    (pc != 2'd0) |-> ((el > {1'b0, pc}) && (el <= 3'd4)))
    else $error("front: held bytes do not fit the sequence length");
`endif

endmodule

[hw/rtl/u2g_queue.sv]
`timescale 1ns / 1ps

module u2g_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  u2g_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output u2g_pkg::job_t pop_job
);

  u2g_pkg::job_t entries [u2g_pkg::QDEPTH];
  logic [u2g_pkg::QPTR_W-1:0] wr_ptr;
  logic [u2g_pkg::QPTR_W-1:0] rd_ptr;
  logic [u2g_pkg::QPTR_W:0]   count;
  logic do_push;
  logic do_pop;

  assign full      = (count == (u2g_pkg::QPTR_W + 1)'(u2g_pkg::QDEPTH));
  assign not_empty = (count != '0);
  assign pop_job   = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + (u2g_pkg::QPTR_W + 1)'(1);
        2'b01:   count <= count - (u2g_pkg::QPTR_W + 1)'(1);
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count: assert property (@(posedge clk) disable iff (rst)
    count <= (u2g_pkg::QPTR_W + 1)'(u2g_pkg::QDEPTH))
    else $error("queue: occupancy beyond depth");
`endif

endmodule

[hw/rtl/u2g_back.sv]
`timescale 1ns / 1ps

module u2g_back #(
  parameter int MAP_ENTRIES = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  u2g_pkg::job_t q_job,
  output logic          q_pop,
  input  logic [7:0]    rep_glyph,
  input  logic [6:0]    entries_used,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    glyph,
  output logic [20:0]   codepoint,
  output logic          malformed,
  output logic          unmapped,
  output logic          last
);

  localparam int AW = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
  localparam int LW = ($clog2(MAP_ENTRIES + 1) > 7) ? $clog2(MAP_ENTRIES + 1) : 7;

  u2g_pkg::bk_state_t state;
  u2g_pkg::bk_state_t state_next;
  logic [1:0]    flush_left;
  u2g_pkg::tail_t tail;
  logic [20:0]   cp_r;
  logic [LW-1:0] idx;
  logic [LW-1:0] idx_inc;
  logic [LW-1:0] limit;
  logic [LW-1:0] used_ext;
  logic [7:0]    res_glyph;
  logic          res_unmapped;

  logic          free;
  logic          printable;
  logic          hit;
  logic          at_end;
  logic [15:0]   load_wide;

  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [28:0]   ram_rdata;
  logic [20:0]   rd_cp;
  logic [7:0]    rd_glyph;

  logic          emit;
  logic [7:0]    e_glyph;
  logic [20:0]   e_cp;
  logic          e_bad;
  logic          e_miss;
  logic          e_last;

  assign free      = !out_valid || out_ready;
  assign used_ext  = LW'(entries_used);
  assign limit     = (used_ext < LW'(MAP_ENTRIES)) ? used_ext : LW'(MAP_ENTRIES);
  assign printable = (cp_r >= 21'h20) && (cp_r <= 21'h7e);
  assign idx_inc   = idx + LW'(1);
  assign rd_cp     = ram_rdata[28:8];
  assign rd_glyph  = ram_rdata[7:0];
  assign hit       = (rd_cp == cp_r);
  assign at_end    = (idx_inc >= limit);
  assign load_wide = {10'b0, q_job.idx};

  u2g_ram #(
    .WIDTH (29),
    .DEPTH (MAP_ENTRIES)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata ({q_job.cp, q_job.glyph}),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      u2g_pkg::BK_IDLE: begin
        if (q_valid && !q_job.is_load) begin
          state_next = (q_job.flush_count != 2'd0) ? u2g_pkg::BK_FLUSH : u2g_pkg::BK_TAIL;
        end
      end
      u2g_pkg::BK_FLUSH: begin
        if (free && (flush_left == 2'd1)) begin
          state_next = (tail == u2g_pkg::TAIL_NONE) ? u2g_pkg::BK_IDLE : u2g_pkg::BK_TAIL;
        end
      end
      u2g_pkg::BK_TAIL: begin
        if (tail == u2g_pkg::TAIL_CP && !printable && (limit != '0)) begin
          state_next = u2g_pkg::BK_CMP;
        end else if (free) begin
          state_next = u2g_pkg::BK_IDLE;
        end
      end
      u2g_pkg::BK_CMP: begin
        if (hit || at_end) begin
          state_next = u2g_pkg::BK_EMIT;
        end
      end
      u2g_pkg::BK_EMIT: begin
        if (free) begin
          state_next = u2g_pkg::BK_IDLE;
        end
      end
      default: state_next = u2g_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    ram_we   = 1'b0;
    ram_addr = '0;
    emit     = 1'b0;
    e_glyph  = rep_glyph;
    e_cp     = '0;
    e_bad    = 1'b0;
    e_miss   = 1'b0;
    e_last   = 1'b0;
    case (state)
      u2g_pkg::BK_IDLE: begin
        q_pop = q_valid;
        if (q_valid && q_job.is_load) begin
          ram_we   = 1'b1;
          ram_addr = load_wide[AW-1:0];
        end
      end
      u2g_pkg::BK_FLUSH: begin
        emit   = free;
        e_bad  = 1'b1;
        e_last = (flush_left == 2'd1) && (tail == u2g_pkg::TAIL_NONE);
      end
      u2g_pkg::BK_TAIL: begin
        e_last = 1'b1;
        if (tail == u2g_pkg::TAIL_CP) begin
          e_cp = cp_r;
          if (printable) begin
            emit    = free;
            e_glyph = cp_r[7:0];
          end else if (limit == '0) begin
            emit   = free;
            e_miss = 1'b1;
          end
        end else begin
          emit  = free;
          e_bad = 1'b1;
        end
      end
      u2g_pkg::BK_CMP: begin
        // Issue the next slot's read while comparing the current one.
        ram_addr = idx_inc[AW-1:0];
      end
      u2g_pkg::BK_EMIT: begin
        emit    = free;
        e_glyph = res_glyph;
        e_cp    = cp_r;
        e_miss  = res_unmapped;
        e_last  = 1'b1;
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= u2g_pkg::BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      glyph     <= e_glyph;
      codepoint <= e_cp;
      malformed <= e_bad;
      unmapped  <= e_miss;
      last      <= e_last;
    end
    if (state == u2g_pkg::BK_IDLE && q_valid && !q_job.is_load) begin
      flush_left <= q_job.flush_count;
      tail       <= q_job.tail;
      cp_r       <= q_job.cp;
    end
    if (state == u2g_pkg::BK_FLUSH && emit) begin
      flush_left <= flush_left - 2'd1;
    end
    if (state == u2g_pkg::BK_TAIL) begin
      idx <= '0;
    end
    if (state == u2g_pkg::BK_CMP) begin
      idx          <= idx_inc;
      res_glyph    <= hit ? rd_glyph : rep_glyph;
      res_unmapped <= !hit;
    end
  end

`ifndef SYNTHESIS
  a_search_bound: assert property (@(posedge clk) disable iff (rst)
    (state == u2g_pkg::BK_CMP) |-> (idx < limit))
    else $error("back: search past the table limit");
  a_flush_left: assert property (@(posedge clk) disable iff (rst)
    (state == u2g_pkg::BK_FLUSH) |-> (flush_left != 2'd0))
    else $error("back: flush state with nothing to flush");
  a_bad_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && malformed) |-> (!unmapped && (codepoint == 21'd0)))
    else $error("back: malformed result carries a code point or miss");
`endif

endmodule

[hw/rtl/utf8_to_glyph_decoder.sv]
`timescale 1ns / 1ps

// Channel  Direction  Handshake             Payload
// in       in         in_valid / in_ready   command, data_byte, entry_index,
//                                           entry_codepoint, entry_glyph
// out      out        out_valid / out_ready glyph, codepoint, malformed, unmapped, last
// cfg      in         cfg_write             cfg_index, cfg_data
//
// The front takes a request per cycle while the two-entry job queue has room.
// Back end: a table load is written to the table on dispatch; any other job is dispatched,
// then gives one replacement result per flushed byte and any final result; a searched code
// point first has its slots compared one per cycle until a hit or map_entries_used slots.
// Reset (rst, synchronous) clears sequence state, queue and output, not the table.
// A stalled output holds the back end; the queue then fills and in_ready drops.

module utf8_to_glyph_decoder #(
  parameter int MAP_ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [7:0]  data_byte,
  input  logic [5:0]  entry_index,
  input  logic [20:0] entry_codepoint,
  input  logic [7:0]  entry_glyph,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  glyph,
  output logic [20:0] codepoint,
  output logic        malformed,
  output logic        unmapped,
  output logic        last,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  logic [7:0] replacement_glyph;
  logic [6:0] map_entries_used;

  logic          q_full;
  logic          q_push;
  u2g_pkg::job_t q_in_job;
  logic          q_valid;
  logic          q_pop;
  u2g_pkg::job_t q_out_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      replacement_glyph <= u2g_pkg::REPLACEMENT_RESET;
      map_entries_used  <= 7'd0;
    end else if (cfg_write) begin
      case (cfg_index)
        u2g_pkg::CFG_REPLACEMENT:  replacement_glyph <= cfg_data;
        u2g_pkg::CFG_ENTRIES_USED: map_entries_used  <= cfg_data[6:0];
        default:                   replacement_glyph <= replacement_glyph;
      endcase
    end
  end

  u2g_front #(
    .MAP_ENTRIES (MAP_ENTRIES)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .command         (command),
    .data_byte       (data_byte),
    .entry_index     (entry_index),
    .entry_codepoint (entry_codepoint),
    .entry_glyph     (entry_glyph),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_job           (q_in_job)
  );

  u2g_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_job  (q_in_job),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_job   (q_out_job)
  );

  u2g_back #(
    .MAP_ENTRIES (MAP_ENTRIES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_job        (q_out_job),
    .q_pop        (q_pop),
    .rep_glyph    (replacement_glyph),
    .entries_used (map_entries_used),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .glyph        (glyph),
    .codepoint    (codepoint),
    .malformed    (malformed),
    .unmapped     (unmapped),
    .last         (last)
  );

endmodule
